// ===== hw/rtl/gb5_pkg.sv =====
package gb5_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int LINES         = 5;
    localparam int TAPS          = 5;
    localparam int HALO          = 2;

    localparam int PIX_W    = 8;
    localparam int VAL_W    = 12;
    localparam int ACC_W    = 16;
    localparam int RAM_W    = (LINES - 1) * PIX_W;

    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 16;
    localparam int ROW_W    = HEIGHT_W + 1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int MIN_DIM      = 3;

    localparam int FRAC_BITS = 8;
    localparam int ROUND     = 1 << (FRAC_BITS - 1);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic
    {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        cmd_t             command;
        logic [PIX_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] pixel_out;
        logic             last;
    } out_word_t;

    // border and sequencing flags that travel with a word down the pipe
    typedef struct packed
    {
        logic emit;
        logic last;
        logic top0;
        logic top1;
        logic bot0;
        logic bot1;
        logic left0;
        logic left1;
        logic right0;
        logic right1;
    } tag_t;

    typedef logic [TAPS-1:0][VAL_W-1:0] five_t;

    // slot k holds the sample k places back from the newest one;
    // near flags mark the first two positions of a line, far the last two
    function automatic five_t mirror5(input five_t s, input logic near0, input logic near1,
                                      input logic far0, input logic far1);
        five_t t;
        t[0] = near0 ? s[0] : (near1 ? s[2] : s[4]);
        t[1] = near0 ? s[1] : s[3];
        t[2] = s[2];
        t[3] = far0 ? s[3] : s[1];
        t[4] = far0 ? s[4] : (far1 ? s[2] : s[0]);
        return t;
    endfunction

    // 1 4 6 4 1 weighting, shifts and adds only
    function automatic logic [ACC_W-1:0] binomial5(input five_t t);
        return ACC_W'(t[0])
             + (ACC_W'(t[1]) << 2)
             + (ACC_W'(t[2]) << 2) + (ACC_W'(t[2]) << 1)
             + (ACC_W'(t[3]) << 2)
             + ACC_W'(t[4]);
    endfunction

endpackage

// ===== hw/rtl/gb5_line_ram.sv =====
module gb5_line_ram #(
    parameter int DEPTH  = gb5_pkg::MAX_WIDTH_DEF,
    parameter int DATA_W = gb5_pkg::RAM_W
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/gb5_cfg.sv =====
module gb5_cfg #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gb5_pkg::APB_AW-1:0]         paddr,
    input  logic [gb5_pkg::APB_DW-1:0]         pwdata,
    output logic [gb5_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    output logic [$clog2(MAX_WIDTH+1)-1:0]     eff_w,
    output logic [gb5_pkg::HEIGHT_W-1:0]       eff_h,
    output logic                               restart
);

    import gb5_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > WIDTH_W) ? WW : WIDTH_W;

    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [CW-1:0]       width_wide, width_clamp;
    reg_idx_t            idx;
    logic                wr;

    assign idx     = reg_idx_t'(paddr[2]);
    assign wr      = psel && penable && pwrite;
    assign restart = wr;
    assign pready  = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr)
        begin
            case (idx)
                REG_IMAGE_WIDTH:  width_next  = pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_next = pwdata[HEIGHT_W-1:0];
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(RESET_WIDTH);
            height_reg <= HEIGHT_W'(RESET_HEIGHT);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // out-of-range sizes are pulled into the supported range
    always_comb
    begin
        width_wide = CW'(width_reg);
        if (width_wide < CW'(MIN_DIM))
        begin
            width_clamp = CW'(MIN_DIM);
        end
        else if (width_wide > CW'(MAX_WIDTH))
        begin
            width_clamp = CW'(MAX_WIDTH);
        end
        else
        begin
            width_clamp = width_wide;
        end
    end

    assign eff_w = width_clamp[WW-1:0];
    assign eff_h = (height_reg < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : height_reg;

endmodule

// ===== hw/rtl/gb5_ctrl.sv =====
module gb5_ctrl #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  gb5_pkg::cmd_t                     command,
    input  logic                              restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
    input  logic [gb5_pkg::HEIGHT_W-1:0]      eff_h,
    output logic                              push,
    output logic [$clog2(MAX_WIDTH)-1:0]      col,
    output gb5_pkg::tag_t                     tag
);

    import gb5_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    // in_row runs two rows past the image while the drain words flush it
    logic [ROW_W-1:0]    in_row_reg, in_row_next;
    logic [XW-1:0]       in_col_reg, in_col_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;
    logic [XW-1:0]       out_col_reg, out_col_next;

    logic [WW-1:0]       w_m1, w_m2, in_col_w, out_col_w;
    logic [ROW_W-1:0]    h_row, h_row_p1;
    logic [HEIGHT_W-1:0] h_m1;
    logic                filling, in_wrap, out_wrap;

    assign w_m1      = eff_w - WW'(1);
    assign w_m2      = eff_w - WW'(2);
    assign in_col_w  = WW'(in_col_reg);
    assign out_col_w = WW'(out_col_reg);
    assign h_row     = ROW_W'(eff_h);
    assign h_row_p1  = h_row + ROW_W'(1);
    assign h_m1      = eff_h - HEIGHT_W'(1);

    assign filling  = in_row_reg < h_row;
    assign in_wrap  = in_col_w == w_m1;
    assign out_wrap = out_col_w == w_m1;

    // a drain word before the image is complete does nothing
    assign push = accept && !(filling && command == CMD_DRAIN);
    assign col  = in_col_reg;

    always_comb
    begin
        tag.emit   = (in_row_reg > ROW_W'(HALO))
                  || (in_row_reg == ROW_W'(HALO) && in_col_reg >= XW'(HALO));
        tag.last   = tag.emit && out_row_reg == h_m1 && out_wrap;
        tag.top0   = in_row_reg == ROW_W'(HALO);
        tag.top1   = in_row_reg == ROW_W'(HALO + 1);
        tag.bot0   = in_row_reg == h_row_p1;
        tag.bot1   = in_row_reg == h_row;
        tag.left0  = out_col_reg == '0;
        tag.left1  = out_col_reg == XW'(1);
        tag.right0 = out_wrap;
        tag.right1 = out_col_w == w_m2;
    end

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (restart || (push && tag.last))
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else if (push)
        begin
            in_col_next = in_wrap ? '0 : in_col_reg + XW'(1);
            in_row_next = in_wrap ? in_row_reg + ROW_W'(1) : in_row_reg;
            if (tag.emit)
            begin
                out_col_next = out_wrap ? '0 : out_col_reg + XW'(1);
                out_row_next = out_wrap ? out_row_reg + HEIGHT_W'(1) : out_row_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

endmodule

// ===== hw/rtl/gb5_window.sv =====
module gb5_window (
    input  logic                         clk,
    input  logic                         shift,
    input  logic [gb5_pkg::PIX_W-1:0]    pixel,
    input  logic [gb5_pkg::RAM_W-1:0]    rows,
    input  gb5_pkg::tag_t                tag_in,
    output logic [gb5_pkg::PIX_W-1:0]    blur,
    output logic                         last
);

    import gb5_pkg::*;

    five_t            vslot, vtap, hist_reg, hist_next, htap;
    logic [ACC_W-1:0] vsum, hsum;
    tag_t             tag_reg;

    // column of five rows, newest row in slot 0
    always_comb
    begin
        vslot[0] = VAL_W'(pixel);
        for (int k = 1; k < TAPS; k++)
        begin
            vslot[k] = VAL_W'(rows[(k-1)*PIX_W +: PIX_W]);
        end
    end

    assign vtap      = mirror5(vslot, tag_in.top0, tag_in.top1, tag_in.bot0, tag_in.bot1);
    assign vsum      = binomial5(vtap);
    assign hist_next = {hist_reg[TAPS-2:0], vsum[VAL_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            hist_reg <= hist_next;
            tag_reg  <= tag_in;
        end
    end

    // center column sits two places back in the column history
    assign htap = mirror5(hist_reg, tag_reg.left0, tag_reg.left1,
                          tag_reg.right0, tag_reg.right1);
    assign hsum = binomial5(htap);
    assign blur = PIX_W'((hsum + ACC_W'(ROUND)) >> FRAC_BITS);
    assign last = tag_reg.last;

endmodule

// ===== hw/rtl/gaussian_blur_5x5.sv =====
// channel | direction | handshake           | word
// pix     | in        | pix_valid/pix_stall | in_word_t  {command, pixel_in}
// blur    | out       | blur_valid/blur_stall| out_word_t {pixel_out, last}
// apb     | in/out    | psel/penable/pready | image_width @0x0, image_height @0x4
//
// One word per clock sustained while blur_stall is low, set by the line RAM's one
// read and one write per clock. A result leaves the output register 2*W+2 words
// behind the input, once its last word has passed stage 1 and the column history.
// Reset clears the position counters and the stage valid flags and loads
// 640x480; the line RAM is not cleared. blur_stall backs up through the input
// stage, the column-history stage and the output register; pix_stall rises only
// once all three hold words. A register write restarts the image.
module gaussian_blur_5x5 #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        pix_valid,
    output logic                        pix_stall,
    input  gb5_pkg::in_word_t           pix_data,

    output logic                        blur_valid,
    input  logic                        blur_stall,
    output gb5_pkg::out_word_t          blur_data,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gb5_pkg::APB_AW-1:0]  paddr,
    input  logic [gb5_pkg::APB_DW-1:0]  pwdata,
    output logic [gb5_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    import gb5_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                restart;

    logic                accept, push;
    logic [XW-1:0]       col;
    tag_t                tag;

    // stage 1: accepted word, RAM read in flight
    logic                v1_reg, v1_next;
    logic [PIX_W-1:0]    pix1_reg;
    tag_t                tag1_reg;
    logic [XW-1:0]       col1_reg;
    logic [RAM_W-1:0]    rows;

    // stage 2: column history holds a word that still owes a result
    logic                v2_reg, v2_next;
    logic [PIX_W-1:0]    win_blur;
    logic                win_last;

    // stage 3: output register
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_word_reg;

    logic                s3_ready, s2_free, s2_adv, s1_free, s1_adv;

    // ready ripples back from the output register
    assign s3_ready = !out_valid_reg || !blur_stall;
    assign s2_adv   = v2_reg && s3_ready;
    assign s2_free  = !v2_reg || s3_ready;
    assign s1_adv   = v1_reg && s2_free;
    assign s1_free  = !v1_reg || s2_free;

    assign pix_stall = !s1_free;
    assign accept    = pix_valid && !pix_stall;

    gb5_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eff_w   (eff_w),
        .eff_h   (eff_h),
        .restart (restart)
    );

    gb5_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (pix_data.command),
        .restart (restart),
        .eff_w   (eff_w),
        .eff_h   (eff_h),
        .push    (push),
        .col     (col),
        .tag     (tag)
    );

    // each RAM word holds the four previous rows of one column; the
    // write-back shifts the new pixel in as the row ages by one
    gb5_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (RAM_W)
    ) u_line_ram (
        .clk     (clk),
        .rd_en   (push),
        .rd_addr (col),
        .rd_data (rows),
        .wr_en   (s1_adv),
        .wr_addr (col1_reg),
        .wr_data ({rows[RAM_W-PIX_W-1:0], pix1_reg})
    );

    gb5_window u_window (
        .clk    (clk),
        .shift  (s1_adv),
        .pixel  (pix1_reg),
        .rows   (rows),
        .tag_in (tag1_reg),
        .blur   (win_blur),
        .last   (win_last)
    );

    always_comb
    begin
        v1_next = v1_reg;
        if (push)
        begin
            v1_next = 1'b1;
        end
        else if (s1_adv)
        begin
            v1_next = 1'b0;
        end
    end

    // words that only fill the line store never occupy stage 2
    always_comb
    begin
        v2_next = v2_reg;
        if (s1_adv)
        begin
            v2_next = tag1_reg.emit;
        end
        else if (s2_adv)
        begin
            v2_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!blur_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pix1_reg <= pix_data.pixel_in;
            tag1_reg <= tag;
            col1_reg <= col;
        end
        if (s2_adv)
        begin
            out_word_reg.pixel_out <= win_blur;
            out_word_reg.last      <= win_last;
        end
    end

    assign blur_valid = out_valid_reg;
    assign blur_data  = out_word_reg;

endmodule

// ===== hw/rtl/gb5_checker.sv =====
module gb5_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pix_stall,
    input logic                        blur_valid,
    input logic                        blur_stall,
    input gb5_pkg::out_word_t          blur_data,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [gb5_pkg::APB_AW-1:0]  paddr,
    input logic [gb5_pkg::APB_DW-1:0]  pwdata,
    input logic [gb5_pkg::APB_DW-1:0]  prdata
);

    import gb5_pkg::*;

    logic wr_width, wr_height;

    assign wr_width  = psel && penable && pwrite
                    && (reg_idx_t'(paddr[2]) == REG_IMAGE_WIDTH);
    assign wr_height = psel && penable && pwrite
                    && (reg_idx_t'(paddr[2]) == REG_IMAGE_HEIGHT);

    // a stalled result holds
    a_blur_hold: assert property (@(posedge clk) disable iff (!rst_n)
        blur_valid && blur_stall |=> blur_valid && $stable(blur_data))
        else $error("stalled result changed");

    // the input side only backs up behind a stalled, full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> blur_valid && blur_stall)
        else $error("input stalled with output free");

    a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
        wr_width ##1 (reg_idx_t'(paddr[2]) == REG_IMAGE_WIDTH)
        |-> prdata == APB_DW'($past(pwdata[WIDTH_W-1:0])))
        else $error("image_width readback mismatch");

    a_height_rb: assert property (@(posedge clk) disable iff (!rst_n)
        wr_height ##1 (reg_idx_t'(paddr[2]) == REG_IMAGE_HEIGHT)
        |-> prdata == APB_DW'($past(pwdata[HEIGHT_W-1:0])))
        else $error("image_height readback mismatch");

endmodule

bind gaussian_blur_5x5 gb5_checker u_gb5_checker (.*);
